FILE: rtl/core/ipoh_pkg.sv
// ============================================================================
// IPv6 option header checker package
// Shared item types, parse phases and verdict codes.
// ============================================================================
package ipoh_pkg;

    // Parse phase of the option walk
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_TYPE   = 3'd2,
        PH_OPTLEN = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    // Verdict codes
    localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [1:0] VERDICT_SILENT  = 2'd1;
    localparam logic [1:0] VERDICT_REPORT  = 2'd2;

    // Error kinds
    localparam logic [1:0] KIND_NONE       = 2'd0;
    localparam logic [1:0] KIND_SHORT      = 2'd1;
    localparam logic [1:0] KIND_OVERRUN    = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN    = 2'd3;

    // Option types
    localparam logic [7:0] OPT_PAD1        = 8'd0;
    localparam logic [7:0] OPT_PADN        = 8'd1;

    // Unknown option actions (top two type bits)
    localparam logic [1:0] ACT_SKIP        = 2'd0;
    localparam logic [1:0] ACT_DISCARD     = 2'd1;
    localparam logic [1:0] ACT_REPORT      = 2'd2;
    localparam logic [1:0] ACT_REPORT_UCAST = 2'd3;

    // Next-header and length bytes that precede the options
    localparam logic [15:0] FIXED_BYTES    = 16'd2;

    // One input item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] packet_size;
        logic        dst_multicast;
    } t_item;

    // One result item
    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  error_kind;
        logic [10:0] problem_offset;
        logic [11:0] header_length;
    } t_result;

endpackage

FILE: rtl/core/ipoh_stream_if.sv
// ============================================================================
// IPv6 option header checker channels
// Valid/ready channels for packet bytes in and verdicts out.
// ============================================================================
interface ipoh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] packet_size;
    logic        dst_multicast;

    modport source (output valid, output data_byte, output first_byte,
                    output packet_size, output dst_multicast, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input packet_size, input dst_multicast, output ready);
endinterface

interface ipoh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [1:0]  error_kind;
    logic [10:0] problem_offset;
    logic [11:0] header_length;

    modport source (output valid, output verdict, output error_kind,
                    output problem_offset, output header_length, input ready);
    modport sink   (input valid, input verdict, input error_kind,
                    input problem_offset, input header_length, output ready);
endinterface

FILE: rtl/core/ipoh_in_reg.sv
// ============================================================================
// IPv6 option header checker input register
// Captures one item and holds it until the parser takes it.
// ============================================================================
module ipoh_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipoh_in_if.sink        i_in,
    input  logic           i_down_ready,
    output logic           o_valid,
    output ipoh_pkg::t_item o_item
);

    logic            r_valid;
    ipoh_pkg::t_item r_item;
    logic            w_accept;

    // Take a new item when empty or when the held one moves on
    assign i_in.ready = !r_valid || i_down_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.data_byte     <= i_in.data_byte;
            r_item.first_byte    <= i_in.first_byte;
            r_item.packet_size   <= i_in.packet_size;
            r_item.dst_multicast <= i_in.dst_multicast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/ipoh_parser.sv
// ============================================================================
// IPv6 option header parser
// Walks the options one byte per cycle while the result register is free or being drained, and registers the verdict.
// ============================================================================
module ipoh_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  ipoh_pkg::t_item i_item,
    input  logic            i_report_en,
    output logic            o_ready,
    ipoh_out_if.source      o_out
);

    ipoh_pkg::t_phase  r_phase,  n_phase;
    logic [11:0]       r_off,    n_off;
    logic [11:0]       r_hb,     n_hb;
    logic [15:0]       r_pkt,    n_pkt;
    logic [7:0]        r_olen,   n_olen;
    logic [7:0]        r_type,   n_type;
    logic [10:0]       r_start,  n_start;
    logic              r_out_valid;
    ipoh_pkg::t_result r_res;

    logic              w_go;
    logic              w_fire;
    ipoh_pkg::t_result w_res;
    logic [11:0]       w_off_inc;
    logic [15:0]       w_pkt_dec;
    logic [7:0]        w_olen_dec;
    logic              w_last;
    logic [11:0]       w_hb_new;
    logic [11:0]       w_remain;
    logic [1:0]        w_action;
    logic [7:0]        w_b;

    // Advance when the result register is free or being drained
    assign o_ready = !r_out_valid || o_out.ready;
    assign w_go    = i_item_valid && o_ready;
    assign w_b     = i_item.data_byte;

    // Per-byte counter and compare terms
    always_comb begin
        w_off_inc  = r_off + 12'd1;
        w_pkt_dec  = (r_pkt != 16'd0) ? (r_pkt - 16'd1) : r_pkt;
        w_olen_dec = (r_olen != 8'd0) ? (r_olen - 8'd1) : r_olen;
        w_last     = ({1'b0, w_off_inc} + 13'd1) >= {1'b0, r_hb};
        w_hb_new   = {({1'b0, w_b} + 9'd1), 3'b000};
        w_remain   = w_last ? 12'd0 : (r_hb - 12'd1 - w_off_inc);
        w_action   = r_type[7:6];
    end

    // Next state and result
    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        n_hb    = r_hb;
        n_pkt   = r_pkt;
        n_olen  = r_olen;
        n_type  = r_type;
        n_start = r_start;
        w_fire  = 1'b0;
        w_res   = '0;

        if (w_go) begin
            if (i_item.first_byte) begin
                // Restart on a new packet
                n_off   = '0;
                n_hb    = '0;
                n_olen  = '0;
                n_type  = '0;
                n_start = '0;
                if (i_item.packet_size < ipoh_pkg::FIXED_BYTES) begin
                    n_pkt            = '0;
                    n_phase          = ipoh_pkg::PH_IDLE;
                    w_fire           = 1'b1;
                    w_res.verdict    = ipoh_pkg::VERDICT_SILENT;
                    w_res.error_kind = ipoh_pkg::KIND_SHORT;
                end else begin
                    n_pkt   = i_item.packet_size - 16'd1;
                    n_phase = ipoh_pkg::PH_LEN;
                end
            end else if (r_phase != ipoh_pkg::PH_IDLE) begin
                n_off = w_off_inc;
                n_pkt = w_pkt_dec;
                unique case (r_phase)
                    ipoh_pkg::PH_LEN: begin
                        n_hb = w_hb_new;
                        if (({4'b0000, w_hb_new} - ipoh_pkg::FIXED_BYTES) > w_pkt_dec) begin
                            n_phase             = ipoh_pkg::PH_IDLE;
                            w_fire              = 1'b1;
                            w_res.verdict       = ipoh_pkg::VERDICT_SILENT;
                            w_res.error_kind    = ipoh_pkg::KIND_SHORT;
                            w_res.header_length = w_hb_new;
                        end else begin
                            n_phase = ipoh_pkg::PH_TYPE;
                        end
                    end
                    ipoh_pkg::PH_TYPE: begin
                        if (w_b == ipoh_pkg::OPT_PAD1) begin
                            if (w_last) begin
                                n_phase             = ipoh_pkg::PH_IDLE;
                                w_fire              = 1'b1;
                                w_res.header_length = r_hb;
                            end
                        end else if (w_last) begin
                            // Type byte with no room for its length byte
                            n_phase              = ipoh_pkg::PH_IDLE;
                            w_fire               = 1'b1;
                            w_res.verdict        = ipoh_pkg::VERDICT_SILENT;
                            w_res.error_kind     = ipoh_pkg::KIND_OVERRUN;
                            w_res.problem_offset = w_off_inc[10:0];
                            w_res.header_length  = r_hb;
                        end else begin
                            n_type  = w_b;
                            n_start = w_off_inc[10:0];
                            n_phase = ipoh_pkg::PH_OPTLEN;
                        end
                    end
                    ipoh_pkg::PH_OPTLEN: begin
                        if ({4'b0000, w_b} > w_remain) begin
                            n_phase              = ipoh_pkg::PH_IDLE;
                            w_fire               = 1'b1;
                            w_res.verdict        = ipoh_pkg::VERDICT_SILENT;
                            w_res.error_kind     = ipoh_pkg::KIND_OVERRUN;
                            w_res.problem_offset = r_start;
                            w_res.header_length  = r_hb;
                        end else if (r_type == ipoh_pkg::OPT_PADN
                                     || w_action == ipoh_pkg::ACT_SKIP) begin
                            // Skip the option body
                            if (w_b == 8'd0) begin
                                if (w_last) begin
                                    n_phase             = ipoh_pkg::PH_IDLE;
                                    w_fire              = 1'b1;
                                    w_res.header_length = r_hb;
                                end else begin
                                    n_phase = ipoh_pkg::PH_TYPE;
                                end
                            end else begin
                                n_olen  = w_b;
                                n_phase = ipoh_pkg::PH_SKIP;
                            end
                        end else begin
                            // Unknown option: discard, maybe report
                            n_phase              = ipoh_pkg::PH_IDLE;
                            w_fire               = 1'b1;
                            w_res.error_kind     = ipoh_pkg::KIND_UNKNOWN;
                            w_res.problem_offset = r_start;
                            w_res.header_length  = r_hb;
                            priority if (w_action == ipoh_pkg::ACT_DISCARD) begin
                                w_res.verdict = ipoh_pkg::VERDICT_SILENT;
                            end else if (w_action == ipoh_pkg::ACT_REPORT) begin
                                w_res.verdict = i_report_en ? ipoh_pkg::VERDICT_REPORT
                                                            : ipoh_pkg::VERDICT_SILENT;
                            end else begin
                                w_res.verdict = (i_report_en && !i_item.dst_multicast)
                                                ? ipoh_pkg::VERDICT_REPORT
                                                : ipoh_pkg::VERDICT_SILENT;
                            end
                        end
                    end
                    ipoh_pkg::PH_SKIP: begin
                        n_olen = w_olen_dec;
                        if (w_olen_dec == 8'd0) begin
                            if (w_last) begin
                                n_phase             = ipoh_pkg::PH_IDLE;
                                w_fire              = 1'b1;
                                w_res.header_length = r_hb;
                            end else begin
                                n_phase = ipoh_pkg::PH_TYPE;
                            end
                        end
                    end
                    default: begin
                        n_phase = ipoh_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ipoh_pkg::PH_IDLE;
            r_off   <= '0;
            r_hb    <= '0;
            r_pkt   <= '0;
            r_olen  <= '0;
            r_type  <= '0;
            r_start <= '0;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_hb    <= n_hb;
            r_pkt   <= n_pkt;
            r_olen  <= n_olen;
            r_type  <= n_type;
            r_start <= n_start;
        end
    end

    // Result register: load on a verdict, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.verdict        = r_res.verdict;
    assign o_out.error_kind     = r_res.error_kind;
    assign o_out.problem_offset = r_res.problem_offset;
    assign o_out.header_length  = r_res.header_length;

endmodule

FILE: rtl/core/ipv6_option_header_checker.sv
// ============================================================================
// IPv6 option header checker
// Parses Hop-by-Hop / Destination Options headers and gives one verdict
// per packet.
// ============================================================================
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   data_byte, first_byte, packet_size, dst_multicast
//  o_out     out  valid/ready   verdict, error_kind, problem_offset, header_length
//  i_cfg     in   i_cfg_we      i_cfg_wdata = error_report_enable
//
//  One byte per cycle while no verdict is stalled; the byte that decides a
//  verdict lands in the input register once taken, and the parser's result
//  register then loads the verdict.
//  Reset (synchronous, active low) returns the parser to idle and sets
//  error reporting on. A stalled verdict holds the parser; the input
//  register still takes one more byte.
// ============================================================================
module ipv6_option_header_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    ipoh_in_if.sink    i_in,
    ipoh_out_if.source o_out
);

    logic            r_report_en;
    logic            w_item_valid;
    ipoh_pkg::t_item w_item;
    logic            w_parser_ready;

    // Error report enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_report_en <= i_cfg_wdata;
        end
    end

    ipoh_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_down_ready (w_parser_ready),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    ipoh_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .i_report_en  (r_report_en),
        .o_ready      (w_parser_ready),
        .o_out        (o_out)
    );

endmodule
